// ----- rtl/core/gvfs_pkg.sv -----
// ----------------------------------------------------------------------------
// gvfs_pkg
// Types and constants for the Gaussian vector field smoother.
// ----------------------------------------------------------------------------
package gvfs_pkg;

	localparam int unsigned ONE_Q15 = 32768;

	typedef enum logic [2:0] {
		CFG_WIDTH  = 3'd0,
		CFG_HEIGHT = 3'd1,
		CFG_RADIUS = 3'd2,
		CFG_W1     = 3'd3,
		CFG_W2     = 3'd4,
		CFG_W3     = 3'd5,
		CFG_W4     = 3'd6,
		CFG_W5     = 3'd7
	} cfg_idx_t;

	typedef enum logic {
		OP_STORE = 1'b0,
		OP_QUERY = 1'b1
	} opcode_t;

	typedef struct packed {
		logic               opcode;
		logic [7:0]         row;
		logic [7:0]         col;
		logic signed [15:0] vec_x;
		logic signed [15:0] vec_y;
	} in_word_t;

	typedef struct packed {
		logic signed [15:0] smooth_x;
		logic signed [15:0] smooth_y;
	} out_word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DIV,
		ST_OUT
	} state_t;

	// Start/done between sequencer and divider
	typedef struct packed {
		logic start;
		logic done;
	} div_ctl_t;

endpackage

// ----- rtl/core/gaussian_vector_field_smoother.sv -----
// ----------------------------------------------------------------------------
// gaussian_vector_field_smoother
// Normalized Gaussian smoothing of a stored 2D motion vector field.
// ----------------------------------------------------------------------------
// Store: no result. Query: (2R+1)^2 taps scanned through the one-read field
// memory, then the MAC drain, then the x and y dividers in parallel (skipped
// for a query outside the frame, whose result is zero), then the result word.
// One item in flight. Reset returns control and config registers to their
// defaults; field memory contents are undefined until written.
module gaussian_vector_field_smoother #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256,
	parameter int MAX_RADIUS = 5
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  gvfs_pkg::in_word_t in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output gvfs_pkg::out_word_t out_data,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [2:0]        cfg_index,
	input  logic [15:0]       cfg_data
);

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int RW  = $clog2(MAX_HEIGHT);
	localparam int CWE = (CW < 1) ? 1 : CW;
	localparam int RWE = (RW < 1) ? 1 : RW;
	localparam int AW  = CWE + RWE;
	localparam int NW  = 62;
	localparam int DW  = 42;

	gvfs_pkg::state_t state_q, state_d;

	logic [8:0]  width_q, height_q;
	logic [2:0]  radius_q;
	logic [15:0] wt_q [5];

	// sanitized config
	logic [12:0] w_eff, h_eff;
	logic [2:0]  r_eff;

	always_comb begin
		w_eff = (width_q == 9'd0) ? 13'd1 : 13'(width_q);
		if (w_eff > 13'(MAX_WIDTH)) w_eff = 13'(MAX_WIDTH);
		h_eff = (height_q == 9'd0) ? 13'd1 : 13'(height_q);
		if (h_eff > 13'(MAX_HEIGHT)) h_eff = 13'(MAX_HEIGHT);
		r_eff = (radius_q > 3'(MAX_RADIUS)) ? 3'(MAX_RADIUS) : radius_q;
	end

	function automatic logic [15:0] gw(input logic [2:0] d, input logic [15:0] w1,
		input logic [15:0] w2, input logic [15:0] w3, input logic [15:0] w4,
		input logic [15:0] w5);
		logic [15:0] v;
		case (d)
			3'd1: v = w1;
			3'd2: v = w2;
			3'd3: v = w3;
			3'd4: v = w4;
			3'd5: v = w5;
			default: v = 16'd0;
		endcase
		if (d == 3'd0) gw = 16'hFFFF;
		else gw = v;
	endfunction

	function automatic logic [16:0] gsat(input logic [15:0] v, input logic [2:0] d);
		if (d == 3'd0) gsat = 17'(gvfs_pkg::ONE_Q15);
		else if (v > 16'(gvfs_pkg::ONE_Q15)) gsat = 17'(gvfs_pkg::ONE_Q15);
		else gsat = 17'(v);
	endfunction

	// config port
	assign cfg_ready = (state_q == gvfs_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 9'd256;
			height_q <= 9'd256;
			radius_q <= 3'd1;
			for (int i = 0; i < 5; i++) wt_q[i] <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (gvfs_pkg::cfg_idx_t'(cfg_index))
				gvfs_pkg::CFG_WIDTH:  width_q  <= cfg_data[8:0];
				gvfs_pkg::CFG_HEIGHT: height_q <= cfg_data[8:0];
				gvfs_pkg::CFG_RADIUS: radius_q <= cfg_data[2:0];
				gvfs_pkg::CFG_W1:     wt_q[0]  <= cfg_data;
				gvfs_pkg::CFG_W2:     wt_q[1]  <= cfg_data;
				gvfs_pkg::CFG_W3:     wt_q[2]  <= cfg_data;
				gvfs_pkg::CFG_W4:     wt_q[3]  <= cfg_data;
				gvfs_pkg::CFG_W5:     wt_q[4]  <= cfg_data;
				default: ;
			endcase
		end
	end

	// input accept
	logic in_acc;
	assign in_stall = (state_q != gvfs_pkg::ST_IDLE);
	assign in_acc   = in_valid && !in_stall;

	logic is_store, store_ok, is_query, q_inframe;
	assign is_store = in_data.opcode == gvfs_pkg::OP_STORE;
	assign is_query = in_data.opcode == gvfs_pkg::OP_QUERY;
	assign store_ok = (13'(in_data.row) < 13'(MAX_HEIGHT)) &&
		(13'(in_data.col) < 13'(MAX_WIDTH));
	assign q_inframe = (13'(in_data.row) < h_eff) && (13'(in_data.col) < w_eff);

	// tap scan counters: offsets dy, dx in -R..R
	logic signed [4:0] dy_q, dx_q;
	logic [7:0]        crow_q, ccol_q;
	logic              inframe_q;
	logic              scan_last;
	assign scan_last = (dy_q == 5'(r_eff)) && (dx_q == 5'(r_eff));

	logic signed [13:0] ty, tx;
	logic               tap_ok;
	assign ty = 14'(signed'({6'd0, crow_q})) + 14'(dy_q);
	assign tx = 14'(signed'({6'd0, ccol_q})) + 14'(dx_q);
	assign tap_ok = (ty >= 0) && (tx >= 0) && (ty < $signed({1'b0, h_eff})) &&
		(tx < $signed({1'b0, w_eff}));

	logic [2:0] ady, adx;
	assign ady = dy_q[4] ? 3'(-dy_q) : 3'(dy_q);
	assign adx = dx_q[4] ? 3'(-dx_q) : 3'(dx_q);

	// field memory
	logic [AW-1:0] waddr, raddr;
	logic [31:0]   rdata;
	logic          we;
	assign we    = in_acc && is_store && store_ok;
	assign waddr = {RWE'(in_data.row), CWE'(in_data.col)};
	assign raddr = {RWE'(ty[12:0]), CWE'(tx[12:0])};

	gvfs_field #(.AW(AW)) u_field (
		.clk(clk), .we(we), .waddr(waddr),
		.wdata({in_data.vec_y, in_data.vec_x}),
		.raddr(raddr), .rdata(rdata)
	);

	// stage 1: per-axis weights, valid
	logic        v_s1, v_s2;
	logic [16:0] gy_s1, gx_s1;
	logic [33:0] wt_s2;
	logic [31:0] word_s2;
	logic signed [49:0] px_s3, py_s3;
	logic [33:0] wt_s3;
	logic        v_s3;

	logic signed [NW-1:0] sx_q, sy_q;
	logic [DW-1:0]        sw_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= (state_q == gvfs_pkg::ST_SCAN) && tap_ok;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		gy_s1   <= gsat(gw(ady, wt_q[0], wt_q[1], wt_q[2], wt_q[3], wt_q[4]), ady);
		gx_s1   <= gsat(gw(adx, wt_q[0], wt_q[1], wt_q[2], wt_q[3], wt_q[4]), adx);
		wt_s2   <= gy_s1 * gx_s1;
		word_s2 <= rdata;
		px_s3   <= $signed(word_s2[15:0]) * $signed({1'b0, wt_s2[31:0]});
		py_s3   <= $signed(word_s2[31:16]) * $signed({1'b0, wt_s2[31:0]});
		wt_s3   <= wt_s2;
		if (in_acc) begin
			sx_q <= '0;
			sy_q <= '0;
			sw_q <= '0;
		end else if (v_s3) begin
			sx_q <= sx_q + NW'(px_s3);
			sy_q <= sy_q + NW'(py_s3);
			sw_q <= sw_q + DW'(wt_s3);
		end
	end

	// dividers
	logic div_start;
	logic dx_done, dy_done;
	logic signed [NW-1:0] qx, qy;
	gvfs_pkg::div_ctl_t dctl;
	assign dctl = {div_start, dx_done};

	gvfs_div #(.NW(NW), .DW(DW)) u_divx (
		.clk(clk), .arst_n(arst_n), .start(dctl.start), .num(sx_q), .den(sw_q),
		.done(dx_done), .quo(qx)
	);
	gvfs_div #(.NW(NW), .DW(DW)) u_divy (
		.clk(clk), .arst_n(arst_n), .start(dctl.start), .num(sy_q), .den(sw_q),
		.done(dy_done), .quo(qy)
	);

	logic [2:0] drain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= gvfs_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		case (state_q)
			gvfs_pkg::ST_IDLE:
				if (in_acc && is_query) state_d = gvfs_pkg::ST_SCAN;
			gvfs_pkg::ST_SCAN:
				if (scan_last) state_d = gvfs_pkg::ST_DRAIN;
			gvfs_pkg::ST_DRAIN:
				if (drain_q == 3'd3) begin
					div_start = inframe_q;
					state_d = inframe_q ? gvfs_pkg::ST_DIV : gvfs_pkg::ST_OUT;
				end
			gvfs_pkg::ST_DIV:
				if (dctl.done) state_d = gvfs_pkg::ST_OUT;
			gvfs_pkg::ST_OUT:
				if (!out_stall) state_d = gvfs_pkg::ST_IDLE;
			default: state_d = gvfs_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dy_q <= '0;
			dx_q <= '0;
			drain_q <= '0;
			inframe_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (in_acc && is_query) begin
				dy_q <= -5'(r_eff);
				dx_q <= -5'(r_eff);
				inframe_q <= q_inframe;
			end else if (state_q == gvfs_pkg::ST_SCAN && !scan_last) begin
				if (dx_q == 5'(r_eff)) begin
					dx_q <= -5'(r_eff);
					dy_q <= dy_q + 5'd1;
				end else begin
					dx_q <= dx_q + 5'd1;
				end
			end
			drain_q <= (state_q == gvfs_pkg::ST_DRAIN) ? drain_q + 3'd1 : 3'd0;
			out_valid <= (state_d == gvfs_pkg::ST_OUT);
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			crow_q <= in_data.row;
			ccol_q <= in_data.col;
		end
		if (state_q == gvfs_pkg::ST_DRAIN && drain_q == 3'd3 && !inframe_q)
			out_data <= '0;
		else if (state_q == gvfs_pkg::ST_DIV && dctl.done)
			out_data <= {qx[15:0], qy[15:0]};
	end

	// scan offsets stay at or below the kernel radius
	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == gvfs_pkg::ST_SCAN |->
		(dx_q <= $signed(5'(r_eff))) && (dy_q <= $signed(5'(r_eff))))
		else $error("scan offset out of kernel");
	a_div_sync: assert property (@(posedge clk) disable iff (!arst_n)
		dx_done == dy_done) else $error("dividers out of step");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input taken with result pending");

endmodule

// ----- rtl/core/gvfs_div.sv -----
// ----------------------------------------------------------------------------
// gvfs_div
// Signed restoring divider, one quotient bit per cycle, truncates to zero.
// ----------------------------------------------------------------------------
module gvfs_div #(
	parameter int NW = 62,
	parameter int DW = 42
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [NW-1:0] num,
	input  logic        [DW-1:0] den,
	output logic                 done,
	output logic signed [NW-1:0] quo
);

	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] q_q;
	logic [DW:0]   rem_q;
	logic [DW-1:0] den_q;
	logic          neg_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [DW:0]   trial;
	logic [DW:0]   diff;

	assign trial = {rem_q[DW-1:0], q_q[NW-1]};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[NW-1];
			q_q   <= num[NW-1] ? NW'(-num) : num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			if (!diff[DW]) begin
				rem_q <= diff;
				q_q   <= {q_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				q_q   <= {q_q[NW-2:0], 1'b0};
			end
		end
	end

	assign quo = neg_q ? NW'(-$signed(q_q)) : $signed(q_q);

endmodule

// ----- rtl/core/gvfs_field.sv -----
// ----------------------------------------------------------------------------
// gvfs_field
// Motion field memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module gvfs_field #(
	parameter int AW = 16
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [31:0]   wdata,
	input  logic [AW-1:0] raddr,
	output logic [31:0]   rdata
);

	logic [31:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for gaussian_vector_field_smoother. Mirrors the field
// store and configuration, predicts each smoothed vector on acceptance and
// compares results in order, under random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module testbench;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid, in_stall, out_valid, out_stall;
	gvfs_pkg::in_word_t  in_data;
	gvfs_pkg::out_word_t out_data;
	logic      cfg_valid, cfg_ready;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;

	gaussian_vector_field_smoother u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	bit [31:0] field_mem [65536];
	bit        field_set [65536];
	int        cur_w = 256, cur_h = 256, cur_r = 1;
	int        gauss [6] = '{32768, 0, 0, 0, 0, 0};
	gvfs_pkg::in_word_t  pending_words[$];
	gvfs_pkg::out_word_t expected_smooth[$];
	int        errors = 0;
	bit        no_idle = 1'b0;

	function automatic int pick_gap();
		int p;
		p = $urandom_range(99);
		if (no_idle || p < 55) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic gvfs_pkg::out_word_t smooth_at(int row, int col);
		gvfs_pkg::out_word_t res;
		longint sx, sy, sw, wt;
		int ty, tx;
		bit [31:0] v;
		sx = 0; sy = 0; sw = 0;
		res = '0;
		if (row >= cur_h || col >= cur_w) return res;
		for (int dy = -cur_r; dy <= cur_r; dy++) begin
			ty = row + dy;
			if (ty < 0 || ty >= cur_h) continue;
			for (int dx = -cur_r; dx <= cur_r; dx++) begin
				tx = col + dx;
				if (tx < 0 || tx >= cur_w) continue;
				v = field_mem[ty * 256 + tx];
				wt = longint'(gauss[dy < 0 ? -dy : dy]) * longint'(gauss[dx < 0 ? -dx : dx]);
				sx += longint'($signed(v[15:0])) * wt;
				sy += longint'($signed(v[31:16])) * wt;
				sw += wt;
			end
		end
		res.smooth_x = 16'(sx / sw);
		res.smooth_y = 16'(sy / sw);
		return res;
	endfunction

	// driver
	gvfs_pkg::in_word_t cur_word;
	int       gap_left = 0;
	always @(posedge clk or negedge arst_n) begin
		bit nv;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			nv = in_valid;
			if (in_valid && !in_stall) begin
				if (cur_word.opcode == gvfs_pkg::OP_QUERY)
					expected_smooth.push_back(smooth_at(cur_word.row, cur_word.col));
				else
					field_mem[{cur_word.row, cur_word.col}] = {cur_word.vec_y, cur_word.vec_x};
				nv = 1'b0;
			end
			if (!nv) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_words.size() > 0) begin
					cur_word = pending_words.pop_front();
					in_data <= cur_word;
					nv = 1'b1;
					gap_left = pick_gap();
				end
			end
			in_valid <= nv;
		end
	end

	// monitor
	int stall_left = 0;
	always @(posedge clk or negedge arst_n) begin
		gvfs_pkg::out_word_t e;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_smooth.size() == 0) begin
					$error("result word with none expected");
					errors++;
				end else begin
					e = expected_smooth.pop_front();
					if (out_data.smooth_x !== e.smooth_x) begin
						$error("smooth_x expected %0d got %0d", e.smooth_x, out_data.smooth_x);
						errors++;
					end
					if (out_data.smooth_y !== e.smooth_y) begin
						$error("smooth_y expected %0d got %0d", e.smooth_y, out_data.smooth_y);
						errors++;
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				stall_left = no_idle ? 0 : pick_gap();
				out_stall <= (stall_left > 0);
			end
		end
	end

	task automatic cfg_write(gvfs_pkg::cfg_idx_t idx, int val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= 16'(val);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		val = val & 16'hFFFF;
		case (idx)
			gvfs_pkg::CFG_WIDTH:
				cur_w = (val & 9'h1FF) == 0 ? 1 : ((val & 9'h1FF) > 256 ? 256 : val & 9'h1FF);
			gvfs_pkg::CFG_HEIGHT:
				cur_h = (val & 9'h1FF) == 0 ? 1 : ((val & 9'h1FF) > 256 ? 256 : val & 9'h1FF);
			gvfs_pkg::CFG_RADIUS: cur_r = (val & 7) > 5 ? 5 : val & 7;
			default: gauss[int'(idx) - int'(gvfs_pkg::CFG_W1) + 1] = val > 32768 ? 32768 : val;
		endcase
	endtask

	task automatic wait_idle();
		do @(posedge clk);
		while (pending_words.size() != 0 || in_valid || expected_smooth.size() != 0);
		repeat (300) @(posedge clk);
	endtask

	function automatic void push_store(int row, int col, int vx, int vy);
		gvfs_pkg::in_word_t w;
		w = '0;
		w.opcode = gvfs_pkg::OP_STORE;
		w.row = 8'(row); w.col = 8'(col);
		w.vec_x = 16'(vx); w.vec_y = 16'(vy);
		field_set[row * 256 + col] = 1'b1;
		pending_words.push_back(w);
	endfunction

	// fills any unwritten tap in reach of the current radius first
	function automatic void push_query(int row, int col);
		gvfs_pkg::in_word_t w;
		if (row < cur_h && col < cur_w)
			for (int ty = row - cur_r; ty <= row + cur_r; ty++)
				for (int tx = col - cur_r; tx <= col + cur_r; tx++)
					if (ty >= 0 && ty < cur_h && tx >= 0 && tx < cur_w && !field_set[ty * 256 + tx])
						push_store(ty, tx, $urandom_range(65535), $urandom_range(65535));
		w = '0;
		w.opcode = gvfs_pkg::OP_QUERY;
		w.row = 8'(row); w.col = 8'(col);
		w.vec_x = 16'($urandom_range(65535)); w.vec_y = 16'($urandom_range(65535));
		pending_words.push_back(w);
	endfunction

	task automatic set_all(int w, int h, int r, int g1, int g2, int g3, int g4, int g5);
		cfg_write(gvfs_pkg::CFG_WIDTH, w);
		cfg_write(gvfs_pkg::CFG_HEIGHT, h);
		cfg_write(gvfs_pkg::CFG_RADIUS, r);
		cfg_write(gvfs_pkg::CFG_W1, g1);
		cfg_write(gvfs_pkg::CFG_W2, g2);
		cfg_write(gvfs_pkg::CFG_W3, g3);
		cfg_write(gvfs_pkg::CFG_W4, g4);
		cfg_write(gvfs_pkg::CFG_W5, g5);
	endtask

	function automatic int rand_weight();
		int p;
		p = $urandom_range(9);
		if (p == 0) return 0;
		if (p == 1) return 32768;
		if (p == 2) return $urandom_range(32769, 65535);
		return $urandom_range(32767);
	endfunction

	function automatic int rand_dim();
		int p;
		p = $urandom_range(9);
		if (p == 0) return 256;
		if (p == 1) return $urandom_range(257, 511);
		if (p == 2) return 0;
		return $urandom_range(1, 20);
	endfunction

	initial begin
		in_valid = 1'b0; in_data = '0; out_stall = 1'b0;
		cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
		repeat (7) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// reset settings: center tap only
		push_store(0, 0, 16'h8000, 16'h7FFF);
		push_store(255, 255, 16'h7FFF, 16'h8000);
		push_query(0, 0);
		push_query(255, 255);
		push_query(0, 255);
		push_query(128, 37);
		wait_idle();

		// full weights, clamped radius, 1x1 frame
		set_all(0, 0, 7, 65535, 32768, 40000, 32768, 65535);
		push_query(0, 0);
		push_query(0, 1);
		push_query(1, 0);
		push_query(255, 255);
		wait_idle();

		// oversize frame clamps to memory, corners with full kernel
		set_all(511, 300, 5, 30000, 20000, 10000, 5000, 1000);
		push_query(255, 255);
		push_query(0, 0);
		push_query(5, 250);
		push_store(3, 3, 16'h8000, 16'h8000);
		push_query(3, 3);
		wait_idle();

		set_all(7, 3, 0, 0, 0, 0, 0, 0);
		push_query(2, 6);
		push_query(3, 6);
		push_query(2, 7);
		wait_idle();

		for (int ph = 0; ph < 10; ph++) begin
			set_all(rand_dim(), rand_dim(), $urandom_range(7), rand_weight(), rand_weight(),
				rand_weight(), rand_weight(), rand_weight());
			no_idle = (ph % 4 == 3);
			for (int i = 0; i < 25; i++) begin
				if ($urandom_range(9) < 3)
					push_store($urandom_range(255), $urandom_range(255),
						$urandom_range(65535), $urandom_range(65535));
				else if ($urandom_range(9) < 9)
					push_query($urandom_range((cur_h < 12 ? cur_h : 12) - 1),
						$urandom_range((cur_w < 12 ? cur_w : 12) - 1));
				else
					push_query($urandom_range(255), $urandom_range(255));
			end
			wait_idle();
			no_idle = 1'b0;
		end

		if (errors == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("testbench NOT OK");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/core/gvfs_pkg.sv
rtl/core/gvfs_div.sv
rtl/core/gvfs_field.sv
rtl/core/gaussian_vector_field_smoother.sv
verif/testbench.sv
